// ===== hdl/itfd_pkg.sv =====
// Shared types, constants and tables for the IMU tilt and fall detector.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package itfd_pkg;

  // Rotation steps of the angle unit (clamped to the size of the arctangent table).
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ROT_STEPS        = (ANGLE_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                      : ANGLE_ITERATIONS;

  // Square root unit: 50-bit radicand, one result bit per cycle.
  localparam int SQRT_IN_W  = 50;
  localparam int SQRT_STEPS = SQRT_IN_W / 2;
  localparam int REM_W      = SQRT_STEPS + 2;

  // Angle datapath widths.
  localparam int XY_W      = 40;
  localparam int Z_W       = 32;
  localparam int ANGLE_MAX = 5760;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_LIMIT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIN_LIMIT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOVER_TIME = 3'd3;
  localparam logic [12:0] TILT_LIMIT_RESET   = 13'd2880;
  localparam logic [15:0] SPIN_LIMIT_RESET   = 16'd1600;
  localparam logic [31:0] HOLD_TIME_RESET    = 32'd1000;
  localparam logic [31:0] RECOVER_TIME_RESET = 32'd2000;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_SPIN    = 2'd1,
    CAUSE_HOLD    = 2'd2,
    CAUSE_UPRIGHT = 2'd3
  } cause_t;

  // One input beat as it sits in the queue.
  typedef struct packed {
    op_t                opcode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [31:0] now_ms;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ANG_LOAD,
    ST_ANG_SQRT,
    ST_ANG_INIT,
    ST_ANG_ROT,
    ST_ANG_DONE,
    ST_TILT_SQ,
    ST_TILT_LOAD,
    ST_TILT_SQRT,
    ST_RATE_LOAD,
    ST_RATE_SQRT,
    ST_DECIDE
  } fsm_t;

  // atan(2^-i) in units of 2^-22 degree, rounded.
  function automatic logic [28:0] atan_entry(input logic [4:0] idx);
    logic [28:0] v;
    unique case (idx)
      5'd0:  v = 29'd188743680;
      5'd1:  v = 29'd111421900;
      5'd2:  v = 29'd58872272;
      5'd3:  v = 29'd29884485;
      5'd4:  v = 29'd15000234;
      5'd5:  v = 29'd7507429;
      5'd6:  v = 29'd3754631;
      5'd7:  v = 29'd1877430;
      5'd8:  v = 29'd938729;
      5'd9:  v = 29'd469366;
      5'd10: v = 29'd234683;
      5'd11: v = 29'd117342;
      5'd12: v = 29'd58671;
      5'd13: v = 29'd29335;
      5'd14: v = 29'd14668;
      5'd15: v = 29'd7334;
      5'd16: v = 29'd3667;
      5'd17: v = 29'd1833;
      5'd18: v = 29'd917;
      5'd19: v = 29'd458;
      5'd20: v = 29'd229;
      5'd21: v = 29'd115;
      5'd22: v = 29'd57;
      5'd23: v = 29'd29;
      default: v = 29'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/itfd_front.sv =====
// Front end: accepts input beats and holds them in a two-entry queue.
// Depends on itfd_pkg.
`timescale 1ns / 1ps

module itfd_front
  import itfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  item_t              in_item,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  item_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;

  // A beat is taken while the queue has room.
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop && q_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_full_no_push: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !q_pop) |=> (count == 2'd2))
    else $error("full queue lost an entry");

endmodule

// ===== hdl/itfd_back.sv =====
// Back end: angle, magnitude and fall decision for one queued beat at a time.
// Holds the configuration registers and the output register. Depends on itfd_pkg.
`timescale 1ns / 1ps

module itfd_back
  import itfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   q_valid,
  input  item_t                  q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [13:0]     pitch_angle,
  output logic signed [13:0]     roll_angle,
  output logic [12:0]            tilt_size,
  output logic [15:0]            rate_size,
  output logic                   is_tilted,
  output logic                   is_fallen,
  output logic [1:0]             cause_code
);

  // Configuration registers.
  logic [12:0] tilt_limit;
  logic [15:0] spin_limit;
  logic [31:0] hold_time_ms;
  logic [31:0] recover_time_ms;

  // Detector state.
  logic               fallen_flag;
  logic [31:0]        fall_start_time;
  logic [31:0]        last_tilt_time;
  cause_t             cause_state;
  logic signed [13:0] held_pitch;
  logic signed [13:0] held_roll;
  logic [12:0]        held_tilt;
  logic [15:0]        held_rate;
  logic               held_tilted;

  // Working registers.
  fsm_t               state, state_next;
  item_t              cur;
  logic [31:0]        ax2, ay2, az2, gx2, gy2, gz2;
  logic [32:0]        den_p, den_r;
  logic [31:0]        rate_sum;
  logic               ang_sel;
  logic signed [13:0] new_pitch, new_roll;
  logic [27:0]        p2, r2;
  logic [12:0]        new_tilt;

  // Square root unit.
  logic [SQRT_IN_W-1:0] sq_val;
  logic [REM_W-1:0]     sq_rem;
  logic [SQRT_STEPS-1:0] sq_root;
  logic [4:0]           sq_cnt;
  logic [REM_W+1:0]     sq_shift, sq_trial;
  logic                 sq_ge;
  logic                 sq_last;

  // Rotation unit.
  logic signed [XY_W-1:0] rx, ry, rxs, rys;
  logic signed [Z_W-1:0]  rz, ratan;
  logic [4:0]             rot_cnt;
  logic                   rot_last;

  // Angle finish.
  logic signed [Z_W+1:0] z_round, z_shift;
  logic signed [13:0]    angle_sat;
  logic [32:0]           den_sel;
  logic                  den_small;
  logic signed [15:0]    ang_a;

  // Decision.
  logic        out_free;
  logic        tilted, spinning, sustained;
  logic [15:0] new_rate;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_limit      <= TILT_LIMIT_RESET;
      spin_limit      <= SPIN_LIMIT_RESET;
      hold_time_ms    <= HOLD_TIME_RESET;
      recover_time_ms <= RECOVER_TIME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TILT_LIMIT:   tilt_limit      <= cfg_data[12:0];
        REG_SPIN_LIMIT:   spin_limit      <= cfg_data[15:0];
        REG_HOLD_TIME:    hold_time_ms    <= cfg_data;
        REG_RECOVER_TIME: recover_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // One square root step: bring down two radicand bits and try to subtract.
  assign sq_shift = {sq_rem, sq_val[SQRT_IN_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_ge    = (sq_shift >= sq_trial);
  assign sq_last  = (sq_cnt == 5'(SQRT_STEPS - 1));

  // One rotation step with floor shifts.
  assign rxs      = rx >>> rot_cnt;
  assign rys      = ry >>> rot_cnt;
  assign ratan    = Z_W'({3'b000, atan_entry(rot_cnt)});
  assign rot_last = (rot_cnt == 5'(ROT_STEPS - 1));

  // Round the accumulated angle to 1/64 degree and saturate.
  assign z_round = {{2{rz[Z_W-1]}}, rz} + (Z_W+2)'(32768);
  assign z_shift = z_round >>> 16;
  always_comb begin
    if (z_shift > (Z_W+2)'(ANGLE_MAX))       angle_sat = 14'(ANGLE_MAX);
    else if (z_shift < -(Z_W+2)'(ANGLE_MAX)) angle_sat = -14'(ANGLE_MAX);
    else                                     angle_sat = z_shift[13:0];
  end

  assign den_sel   = ang_sel ? den_r : den_p;
  assign den_small = (den_sel <= 33'd16);
  assign ang_a     = ang_sel ? cur.accel_y : cur.accel_x;

  // Fall decision from the finished magnitudes.
  assign out_free  = !out_valid || !out_stall;
  assign new_rate  = sq_root[15:0];
  assign tilted    = (new_tilt > tilt_limit);
  assign spinning  = (new_rate > spin_limit);
  assign sustained = tilted && ((cur.now_ms - fall_start_time) > hold_time_ms)
                     && (fall_start_time != 32'd0);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = (q_item.opcode == OP_CLEAR) ? ST_DECIDE : ST_SQUARE;
        end
      end
      ST_SQUARE:    state_next = ST_SUM;
      ST_SUM:       state_next = ST_ANG_LOAD;
      ST_ANG_LOAD: begin
        if (!den_small)   state_next = ST_ANG_SQRT;
        else if (ang_sel) state_next = ST_TILT_SQ;
        else              state_next = ST_ANG_LOAD;
      end
      ST_ANG_SQRT:  if (sq_last) state_next = ST_ANG_INIT;
      ST_ANG_INIT:  state_next = ST_ANG_ROT;
      ST_ANG_ROT:   if (rot_last) state_next = ST_ANG_DONE;
      ST_ANG_DONE:  state_next = ang_sel ? ST_TILT_SQ : ST_ANG_LOAD;
      ST_TILT_SQ:   state_next = ST_TILT_LOAD;
      ST_TILT_LOAD: state_next = ST_TILT_SQRT;
      ST_TILT_SQRT: if (sq_last) state_next = ST_RATE_LOAD;
      ST_RATE_LOAD: state_next = ST_RATE_SQRT;
      ST_RATE_SQRT: if (sq_last) state_next = ST_DECIDE;
      ST_DECIDE:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Datapath working registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur     <= q_item;
        ang_sel <= 1'b0;
      end
      ST_SQUARE: begin
        ax2 <= 32'(cur.accel_x * cur.accel_x);
        ay2 <= 32'(cur.accel_y * cur.accel_y);
        az2 <= 32'(cur.accel_z * cur.accel_z);
        gx2 <= 32'(cur.rate_x * cur.rate_x);
        gy2 <= 32'(cur.rate_y * cur.rate_y);
        gz2 <= 32'(cur.rate_z * cur.rate_z);
      end
      ST_SUM: begin
        den_p    <= {1'b0, ay2} + {1'b0, az2};
        den_r    <= {1'b0, ax2} + {1'b0, az2};
        rate_sum <= gx2 + gy2 + gz2;
      end
      ST_ANG_LOAD: begin
        if (den_small) begin
          if (ang_sel) new_roll <= 14'sd0;
          else         new_pitch <= 14'sd0;
          ang_sel <= 1'b1;
        end
        sq_val  <= {1'b0, den_sel, 16'h0000};
        sq_rem  <= '0;
        sq_root <= '0;
        sq_cnt  <= '0;
      end
      ST_ANG_INIT: begin
        rx      <= XY_W'($signed({1'b0, sq_root}));
        ry      <= XY_W'(ang_a) <<< 8;
        rz      <= '0;
        rot_cnt <= '0;
      end
      ST_ANG_ROT: begin
        if (!ry[XY_W-1]) begin
          rx <= rx + rys;
          ry <= ry - rxs;
          rz <= rz + ratan;
        end else begin
          rx <= rx - rys;
          ry <= ry + rxs;
          rz <= rz - ratan;
        end
        rot_cnt <= rot_cnt + 5'd1;
      end
      ST_ANG_DONE: begin
        if (ang_sel) new_roll <= angle_sat;
        else         new_pitch <= angle_sat;
        ang_sel <= 1'b1;
      end
      ST_TILT_SQ: begin
        p2 <= 28'(new_pitch * new_pitch);
        r2 <= 28'(new_roll * new_roll);
      end
      ST_TILT_LOAD: begin
        sq_val  <= SQRT_IN_W'(p2 + r2);
        sq_rem  <= '0;
        sq_root <= '0;
        sq_cnt  <= '0;
      end
      ST_RATE_LOAD: begin
        new_tilt <= sq_root[12:0];
        sq_val   <= SQRT_IN_W'(rate_sum);
        sq_rem   <= '0;
        sq_root  <= '0;
        sq_cnt   <= '0;
      end
      default: ;
    endcase

    // The square root steps run in all three root states.
    if (state == ST_ANG_SQRT || state == ST_TILT_SQRT || state == ST_RATE_SQRT) begin
      if (sq_ge) begin
        sq_rem  <= REM_W'(sq_shift - sq_trial);
        sq_root <= {sq_root[SQRT_STEPS-2:0], 1'b1};
      end else begin
        sq_rem  <= REM_W'(sq_shift);
        sq_root <= {sq_root[SQRT_STEPS-2:0], 1'b0};
      end
      sq_val <= {sq_val[SQRT_IN_W-3:0], 2'b00};
      sq_cnt <= sq_cnt + 5'd1;
    end
  end

  // Detector state and held sample values.
  always_ff @(posedge clk) begin
    if (rst) begin
      fallen_flag     <= 1'b0;
      fall_start_time <= '0;
      last_tilt_time  <= '0;
      cause_state     <= CAUSE_NONE;
      held_pitch      <= '0;
      held_roll       <= '0;
      held_tilt       <= '0;
      held_rate       <= '0;
      held_tilted     <= 1'b0;
    end else if (state == ST_DECIDE && out_free) begin
      if (cur.opcode == OP_CLEAR) begin
        fallen_flag     <= 1'b0;
        fall_start_time <= '0;
      end else begin
        held_pitch  <= new_pitch;
        held_roll   <= new_roll;
        held_tilt   <= new_tilt;
        held_rate   <= new_rate;
        held_tilted <= tilted;
        if (tilted) last_tilt_time <= cur.now_ms;
        if ((tilted && spinning) || sustained) begin
          if (!fallen_flag) begin
            fallen_flag     <= 1'b1;
            fall_start_time <= cur.now_ms;
            cause_state     <= spinning ? CAUSE_SPIN : CAUSE_HOLD;
          end
        end else if (!tilted && ((cur.now_ms - last_tilt_time) > recover_time_ms)) begin
          fallen_flag     <= 1'b0;
          cause_state     <= CAUSE_UPRIGHT;
          fall_start_time <= '0;
        end
      end
    end
  end

  // Output register: loaded with the state as it stands after this beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DECIDE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && out_free) begin
      if (cur.opcode == OP_CLEAR) begin
        pitch_angle <= held_pitch;
        roll_angle  <= held_roll;
        tilt_size   <= held_tilt;
        rate_size   <= held_rate;
        is_tilted   <= held_tilted;
        is_fallen   <= 1'b0;
        cause_code  <= cause_state;
      end else begin
        pitch_angle <= new_pitch;
        roll_angle  <= new_roll;
        tilt_size   <= new_tilt;
        rate_size   <= new_rate;
        is_tilted   <= tilted;
        if ((tilted && spinning) || sustained) begin
          is_fallen  <= 1'b1;
          cause_code <= fallen_flag ? cause_state : (spinning ? CAUSE_SPIN : CAUSE_HOLD);
        end else if (!tilted && ((cur.now_ms - last_tilt_time) > recover_time_ms)) begin
          is_fallen  <= 1'b0;
          cause_code <= CAUSE_UPRIGHT;
        end else begin
          is_fallen  <= fallen_flag;
          cause_code <= cause_state;
        end
      end
    end
  end

  a_fallen_cause: assert property (@(posedge clk) disable iff (rst)
    fallen_flag |-> (cause_state == CAUSE_SPIN || cause_state == CAUSE_HOLD))
    else $error("fallen without a fall cause");
  a_out_fallen_cause: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_fallen) |-> (cause_code == CAUSE_SPIN || cause_code == CAUSE_HOLD))
    else $error("result reports a fall without a fall cause");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == ST_IDLE && q_valid))
    else $error("queue popped outside idle");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 14'sd5760 && pitch_angle >= -14'sd5760))
    else $error("pitch out of range");

endmodule

// ===== hdl/imu_tilt_fall_detector_top.sv =====
// Channel     Handshake            Payload
// in          in_valid / in_stall  opcode, accel_x..z, rate_x..z, now_ms
// out         out_valid / out_stall pitch_angle, roll_angle, tilt_size, rate_size,
//                                  is_tilted, is_fallen, cause_code
// cfg         cfg_write            cfg_index, cfg_data
//
// A sample beat passes from queue pop to result through four serial square roots of
// 25 steps each on one shared root unit, 16 rotation steps per angle, and the load and
// sequencing states. An angle with a near-zero denominator skips its root and rotation.
// A clear beat skips all of these steps. A stalled result holds the back end until that beat leaves.
// A two-beat input queue keeps accepting while it has room, also while the back end works or is stalled.
// Reset is synchronous; it restores the register defaults and clears the fall state.
// Depends on itfd_pkg, itfd_front and itfd_back.
`timescale 1ns / 1ps

module imu_tilt_fall_detector_top
  import itfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   opcode,
  input  logic signed [15:0]     accel_x,
  input  logic signed [15:0]     accel_y,
  input  logic signed [15:0]     accel_z,
  input  logic signed [15:0]     rate_x,
  input  logic signed [15:0]     rate_y,
  input  logic signed [15:0]     rate_z,
  input  logic [31:0]            now_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [13:0]     pitch_angle,
  output logic signed [13:0]     roll_angle,
  output logic [12:0]            tilt_size,
  output logic [15:0]            rate_size,
  output logic                   is_tilted,
  output logic                   is_fallen,
  output logic [1:0]             cause_code
);

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // Pack the input beat.
  always_comb begin
    in_item.opcode  = op_t'(opcode);
    in_item.accel_x = accel_x;
    in_item.accel_y = accel_y;
    in_item.accel_z = accel_z;
    in_item.rate_x  = rate_x;
    in_item.rate_y  = rate_y;
    in_item.rate_z  = rate_z;
    in_item.now_ms  = now_ms;
  end

  itfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  itfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .tilt_size   (tilt_size),
    .rate_size   (rate_size),
    .is_tilted   (is_tilted),
    .is_fallen   (is_fallen),
    .cause_code  (cause_code)
  );

endmodule

// ===== sim/imu_tilt_fall_detector_top_test.sv =====
// Self-checking testbench for the IMU tilt and fall detector top level.
// Drives sample and clear beats, predicts each result, and compares field by field.
// Depends on itfd_pkg and the detector RTL.
`timescale 1ns / 1ps

module imu_tilt_fall_detector_top_test;
  import itfd_pkg::*;

  // One expected result beat.
  typedef struct {
    logic signed [13:0] pitch;
    logic signed [13:0] roll;
    logic [12:0]        tilt;
    logic [15:0]        rate;
    logic               tilted;
    logic               fallen;
    cause_t             cause;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   opcode = 1'b0;
  logic signed [15:0]     accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0]     rate_x = '0, rate_y = '0, rate_z = '0;
  logic [31:0]            now_ms = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [13:0]     pitch_angle, roll_angle;
  logic [12:0]            tilt_size;
  logic [15:0]            rate_size;
  logic                   is_tilted, is_fallen;
  logic [1:0]             cause_code;

  imu_tilt_fall_detector_top dut (.*);

  always #6 clk = ~clk;

  // Predictor copy of configuration and fall state.
  logic [12:0] lim_tilt;
  logic [15:0] lim_spin;
  logic [31:0] lim_hold, lim_recover;
  logic        fall_flag;
  logic [31:0] fall_start, tilt_stamp;
  cause_t      cause_now;
  verdict_t    held;

  item_t    sample_queue[$];
  verdict_t result_queue[$];
  int       mismatches = 0;
  bit       quiet_sender = 1'b0;
  bit       quiet_receiver = 1'b0;
  bit       calm = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;

  function automatic longint floor_root(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint atan_step(int i);
    longint steps[24] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                          3754631, 1877430, 938729, 469366, 234683, 117342,
                          58671, 29335, 14668, 7334, 3667, 1833,
                          917, 458, 229, 115, 57, 29};
    return steps[i];
  endfunction

  // Vectoring rotation toward the axis; arithmetic shifts floor as required.
  function automatic longint angle_of(longint a, longint b, longint c);
    longint den, x, y, z, xs, ys, r;
    den = b * b + c * c;
    if (den <= 16) return 0;
    x = floor_root(den <<< 16);
    y = a * 256;
    z = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    r = (z + 32768) >>> 16;
    if (r > ANGLE_MAX) r = ANGLE_MAX;
    if (r < -ANGLE_MAX) r = -ANGLE_MAX;
    return r;
  endfunction

  function automatic void predict_detector(item_t s);
    longint p, r;
    logic spinning, sustained, tilted;
    verdict_t v;
    if (s.opcode == OP_CLEAR) begin
      fall_flag = 1'b0;
      fall_start = '0;
    end else begin
      p = angle_of(s.accel_x, s.accel_y, s.accel_z);
      r = angle_of(s.accel_y, s.accel_x, s.accel_z);
      held.pitch = 14'(p);
      held.roll = 14'(r);
      held.tilt = 13'(floor_root(p * p + r * r));
      held.rate = 16'(floor_root(longint'(s.rate_x) * s.rate_x
                                 + longint'(s.rate_y) * s.rate_y
                                 + longint'(s.rate_z) * s.rate_z));
      tilted = held.tilt > lim_tilt;
      spinning = held.rate > lim_spin;
      held.tilted = tilted;
      if (tilted) tilt_stamp = s.now_ms;
      sustained = tilted && (s.now_ms - fall_start) > lim_hold && fall_start != 0;
      if ((tilted && spinning) || sustained) begin
        if (!fall_flag) begin
          fall_flag = 1'b1;
          fall_start = s.now_ms;
          cause_now = spinning ? CAUSE_SPIN : CAUSE_HOLD;
        end
      end else if (!tilted && (s.now_ms - tilt_stamp) > lim_recover) begin
        fall_flag = 1'b0;
        cause_now = CAUSE_UPRIGHT;
        fall_start = '0;
      end
    end
    v = held;
    v.fallen = fall_flag;
    v.cause = cause_now;
    result_queue.push_back(v);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: presents queued beats; a fresh beat is loaded only when the old one is taken.
  always @(posedge clk) begin
    item_t s;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_detector('{opcode: op_t'(opcode), accel_x: accel_x, accel_y: accel_y,
                           accel_z: accel_z, rate_x: rate_x, rate_y: rate_y,
                           rate_z: rate_z, now_ms: now_ms});
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else if (!quiet_sender && sample_queue.size() > 0) begin
          s = sample_queue.pop_front();
          in_valid <= 1'b1;
          opcode <= s.opcode;
          accel_x <= s.accel_x;
          accel_y <= s.accel_y;
          accel_z <= s.accel_z;
          rate_x <= s.rate_x;
          rate_y <= s.rate_y;
          rate_z <= s.rate_z;
          now_ms <= s.now_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted results and stalls the output in random bursts.
  always @(posedge clk) begin
    verdict_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          w = result_queue.pop_front();
          if (pitch_angle !== w.pitch) report_mismatch("pitch_angle", pitch_angle, w.pitch);
          if (roll_angle !== w.roll) report_mismatch("roll_angle", roll_angle, w.roll);
          if (tilt_size !== w.tilt) report_mismatch("tilt_size", tilt_size, w.tilt);
          if (rate_size !== w.rate) report_mismatch("rate_size", rate_size, w.rate);
          if (is_tilted !== w.tilted) report_mismatch("is_tilted", is_tilted, w.tilted);
          if (is_fallen !== w.fallen) report_mismatch("is_fallen", is_fallen, w.fallen);
          if (cause_code !== w.cause) report_mismatch("cause_code", cause_code, w.cause);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!calm && !quiet_receiver && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic item_t make_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                        logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                                        logic [31:0] t);
    item_t s;
    s.opcode = OP_SAMPLE;
    s.accel_x = ax; s.accel_y = ay; s.accel_z = az;
    s.rate_x = gx; s.rate_y = gy; s.rate_z = gz;
    s.now_ms = t;
    return s;
  endfunction

  function automatic item_t make_clear();
    item_t s;
    s = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    s.opcode = OP_CLEAR;
    return s;
  endfunction

  // Random accel near a posture: upright, tilted, or anywhere; sometimes tiny values.
  function automatic logic [15:0] axis_value(int mode);
    case (mode)
      0: return $urandom_range(0, 8) - 4;
      1: return $urandom_range(0, 8000) - 4000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t random_sample(ref logic [31:0] clock_ms);
    logic [15:0] ax, ay, az, gx, gy, gz;
    int pose;
    pose = $urandom_range(0, 9);
    clock_ms += $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 1500);
    if (pose < 4) begin
      // upright: small x and y, gravity on z
      ax = axis_value(1) >>> 3; ay = axis_value(1) >>> 3; az = 4096 + axis_value(1) / 8;
    end else if (pose < 8) begin
      ax = axis_value(1) * 4; ay = axis_value(1); az = axis_value(1) >>> 2;
    end else begin
      ax = axis_value($urandom_range(0, 2)); ay = axis_value($urandom_range(0, 2));
      az = axis_value($urandom_range(0, 2));
    end
    if ($urandom_range(0, 1)) begin
      gx = axis_value(1); gy = axis_value(1); gz = axis_value(1);
    end else begin
      gx = $urandom; gy = $urandom; gz = $urandom;
    end
    return make_sample(ax, ay, az, gx, gy, gz, clock_ms);
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_TILT_LIMIT:   lim_tilt = val[12:0];
      REG_SPIN_LIMIT:   lim_spin = val[15:0];
      REG_HOLD_TIME:    lim_hold = val;
      REG_RECOVER_TIME: lim_recover = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (sample_queue.size() == 0 && !in_valid && result_queue.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    logic [31:0] clock_ms;
    lim_tilt = TILT_LIMIT_RESET;
    lim_spin = SPIN_LIMIT_RESET;
    lim_hold = HOLD_TIME_RESET;
    lim_recover = RECOVER_TIME_RESET;
    fall_flag = 1'b0;
    fall_start = '0;
    tilt_stamp = '0;
    cause_now = CAUSE_NONE;
    held = '{default: '0, cause: CAUSE_NONE};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: extremes, near-zero denominators, spin fall, hold fall, clears.
    sample_queue.push_back(make_clear());
    sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 0, 0));
    sample_queue.push_back(make_sample(16'h7fff, 16'h7fff, 16'h7fff,
                                       16'h7fff, 16'h7fff, 16'h7fff, 32'hffff_ffff));
    sample_queue.push_back(make_sample(16'h8000, 16'h8000, 16'h8000,
                                       16'h8000, 16'h8000, 16'h8000, 5));
    sample_queue.push_back(make_sample(100, 4, 0, 0, 0, 0, 10));
    sample_queue.push_back(make_sample(-100, 0, -4, 0, 0, 0, 11));
    sample_queue.push_back(make_sample(3, 5, 0, 0, 0, 0, 12));
    sample_queue.push_back(make_sample(4096, 0, 0, 2000, 0, 0, 0));
    sample_queue.push_back(make_sample(4096, 0, 0, 2000, 0, 0, 50));
    sample_queue.push_back(make_clear());
    sample_queue.push_back(make_sample(0, -4096, 10, 0, 0, 0, 100));
    sample_queue.push_back(make_sample(0, -4096, 10, 0, 0, 3000, 200));
    sample_queue.push_back(make_sample(0, -4096, 10, 0, 0, 0, 1300));
    sample_queue.push_back(make_clear());
    sample_queue.push_back(make_sample(0, -4096, 10, 0, 0, 0, 1400));
    sample_queue.push_back(make_sample(0, 0, 4096, 0, 0, 0, 32'hffff_fff0));
    sample_queue.push_back(make_sample(0, 0, 4096, 0, 0, 0, 3000));
    sample_queue.push_back(make_sample(0, 0, 4096, 0, 0, 0, 9000));
    sample_queue.push_back(make_sample(16'h8000, 0, 0, 16'h7fff, 0, 0, 9100));
    sample_queue.push_back(make_clear());

    // The sender holds off once, mid-stream, until every expected result has come.
    drain();
    for (int k = 0; k < 4; k++) begin
      sample_queue.push_back(make_sample(4096, 4096, 0, 5000, 5000, 0, 32'(77 + k)));
    end
    repeat (40) @(posedge clk);
    quiet_sender = 1'b1;
    wait (!in_valid && result_queue.size() == 0);
    repeat (50) @(posedge clk);
    quiet_sender = 1'b0;
    drain();

    // Random phases over several settings, extremes included.
    clock_ms = 1;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin write_reg(REG_TILT_LIMIT, 0); write_reg(REG_SPIN_LIMIT, 0);
                 write_reg(REG_HOLD_TIME, 0); write_reg(REG_RECOVER_TIME, 0); end
        1: begin write_reg(REG_TILT_LIMIT, 32'hffff_ffff); write_reg(REG_SPIN_LIMIT, 56756);
                 write_reg(REG_HOLD_TIME, 32'hffff_ffff);
                 write_reg(REG_RECOVER_TIME, 32'hffff_ffff); end
        2: begin write_reg(REG_TILT_LIMIT, 8147); write_reg(REG_SPIN_LIMIT, 16'hffff); end
        3: begin write_reg(3'd7, 32'h1234); write_reg(REG_TILT_LIMIT, 2880);
                 write_reg(REG_SPIN_LIMIT, 1600); write_reg(REG_HOLD_TIME, 1000);
                 write_reg(REG_RECOVER_TIME, 2000); end
        default: begin write_reg(REG_TILT_LIMIT, $urandom_range(500, 5000));
                 write_reg(REG_SPIN_LIMIT, $urandom_range(0, 20000));
                 write_reg(REG_HOLD_TIME, $urandom_range(0, 3000));
                 write_reg(REG_RECOVER_TIME, $urandom_range(0, 4000)); end
      endcase
      calm = (phase == 6);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 14) == 0) sample_queue.push_back(make_clear());
        else sample_queue.push_back(random_sample(clock_ms));
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog well above the slowest run: ~750 beats plus stalls.
  initial begin
    #(12ns * 2_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/itfd_pkg.sv
hdl/itfd_front.sv
hdl/itfd_back.sv
hdl/imu_tilt_fall_detector_top.sv
sim/imu_tilt_fall_detector_top_test.sv
